>>> hdl/p2s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package p2s_pkg;

    // Fraction bits of the sine and cosine values.
    localparam int TRIG_FRAC_BITS = 16;
    localparam int TRIG_SH        = 31 - TRIG_FRAC_BITS;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 1;

    // Taylor terms after the first, one series cell each.
    localparam int N_TERMS   = 7;
    localparam int CELL_LAT  = 3;
    localparam int SER_LAT   = CELL_LAT * N_TERMS;

    // Quotient bits of the range ratio, one divider cell each.
    localparam int DIV_CELLS = 16;

    // Pipeline depth of the bearing-to-angle front end.
    localparam int ANGLE_LAT = 8;

    // Radius in Q.16 pixels: 17-bit ratio times 12-bit radius.
    localparam int R_W = 29;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    // Divisors of the series terms and their 2^32 reciprocals.
    localparam logic [7:0] SIN_DIV [N_TERMS] =
        '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};
    localparam logic [7:0] COS_DIV [N_TERMS] =
        '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
    localparam logic [31:0] SIN_RECIP [N_TERMS] = '{
        32'(64'd4294967296 / 6),   32'(64'd4294967296 / 20),
        32'(64'd4294967296 / 42),  32'(64'd4294967296 / 72),
        32'(64'd4294967296 / 110), 32'(64'd4294967296 / 156),
        32'(64'd4294967296 / 210)};
    localparam logic [31:0] COS_RECIP [N_TERMS] = '{
        32'(64'd4294967296 / 2),   32'(64'd4294967296 / 12),
        32'(64'd4294967296 / 30),  32'(64'd4294967296 / 56),
        32'(64'd4294967296 / 90),  32'(64'd4294967296 / 132),
        32'(64'd4294967296 / 182)};

    // Series state handed from cell to cell.
    typedef struct packed {
        logic [31:0]        ts;
        logic [31:0]        tc;
        logic [30:0]        x2;
        logic signed [33:0] ss;
        logic signed [33:0] cs;
    } ser_t;

    // Per-cell constants of one series term.
    typedef struct packed {
        logic [7:0]  d_sin;
        logic [31:0] m_sin;
        logic [7:0]  d_cos;
        logic [31:0] m_cos;
        logic        neg;
    } ser_coef_t;

    // Partial remainder and quotient of the ratio divider.
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] quot;
        logic        clamp;
    } div_t;

    // Quadrant and octant fold of the bearing.
    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
    } side_t;

endpackage

`default_nettype wire

>>> hdl/polar_to_screen_plotter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Handshake                    Beat contents
// input      start (busy stays low)       target_distance, target_bearing
// result     done, one cycle              pixel_x, pixel_y
// config     APB write, pready always 1   max_range, center_x, center_y, radius_px
//
// One beat is taken every cycle.
// The pipeline is the input register, the eight-stage angle front end, the seven
// three-stage Taylor series cells, then fold, multiply and output stages; the
// sixteen-cell ratio divider runs beside them and its radius is delayed to match.
// rst_n clears the configuration registers and the in-flight valid bits at once.
// The receiver cannot stall, so no result is ever held back.

module polar_to_screen_plotter_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [15:0]        target_distance,
    input  wire logic signed [15:0] target_bearing,
    output logic                    done,
    output logic signed [16:0]      pixel_x,
    output logic signed [16:0]      pixel_y
);
    import p2s_pkg::*;

    localparam logic [1:0] REG_MAX_RANGE = 2'd0;
    localparam logic [1:0] REG_CENTER_X  = 2'd1;
    localparam logic [1:0] REG_CENTER_Y  = 2'd2;
    localparam logic [1:0] REG_RADIUS    = 2'd3;

    localparam int T1_STAGE  = ANGLE_LAT + SER_LAT + 1;
    localparam int R_DLY     = T1_STAGE - (DIV_CELLS + 1);
    localparam int OUT_STAGE = T1_STAGE + 2;
    localparam int SH2       = 16 + TRIG_FRAC_BITS;
    localparam int PROD_W    = R_W + TRIG_W;

    logic [15:0] max_range_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [11:0] radius_reg;
    logic        cfg_wr;

    logic               v_reg [OUT_STAGE+1];
    logic [15:0]        dist_reg;
    logic signed [15:0] bearing_reg;

    div_t        div_bus [DIV_CELLS+1];
    logic [16:0] ratio;
    logic [R_W-1:0] r_reg;
    logic [R_W-1:0] r_dly_reg [R_DLY];

    ser_t  ser_bus [N_TERMS+1];
    side_t side_a;
    side_t side_dly_reg [SER_LAT];

    logic [31:0]       s_clip;
    logic [31:0]       c_clip;
    logic [32:0]       s_rnd;
    logic [32:0]       c_rnd;
    logic [TRIG_W-1:0] s_t;
    logic [TRIG_W-1:0] c_t;
    logic [TRIG_W-1:0] xmag_next;
    logic [TRIG_W-1:0] ymag_next;
    logic              xneg_next;
    logic              ysub_next;
    logic [TRIG_W-1:0] xmag_reg;
    logic [TRIG_W-1:0] ymag_reg;
    logic              xneg_reg;
    logic              ysub_reg;
    logic [PROD_W-1:0] px_prod_reg;
    logic [PROD_W-1:0] py_prod_reg;
    logic              xneg2_reg;
    logic              ysub2_reg;
    logic [PROD_W:0]   px_rnd;
    logic [PROD_W:0]   py_rnd;
    logic [16:0]       offx;
    logic [16:0]       offy;
    logic [16:0]       cx17;
    logic [16:0]       cy17;
    logic [16:0]       pixel_x_next;
    logic [16:0]       pixel_y_next;
    logic [16:0]       pixel_x_reg;
    logic [16:0]       pixel_y_reg;

    // Configuration registers.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg <= '0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MAX_RANGE: max_range_reg <= pwdata[15:0];
                REG_CENTER_X:  center_x_reg  <= pwdata[15:0];
                REG_CENTER_Y:  center_y_reg  <= pwdata[15:0];
                REG_RADIUS:    radius_reg    <= pwdata[11:0];
                default:       max_range_reg <= max_range_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MAX_RANGE: prdata = {16'd0, max_range_reg};
            REG_CENTER_X:  prdata = {16'd0, center_x_reg};
            REG_CENTER_Y:  prdata = {16'd0, center_y_reg};
            REG_RADIUS:    prdata = {20'd0, radius_reg};
            default:       prdata = '0;
        endcase
    end

    // A new beat enters every cycle.
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= OUT_STAGE; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= start && !busy;
            for (int i = 1; i <= OUT_STAGE; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg    <= target_distance;
        bearing_reg <= target_bearing;
    end

    // Range ratio: a row of restoring divider cells.
    assign div_bus[0].rem   = dist_reg;
    assign div_bus[0].quot  = '0;
    assign div_bus[0].clamp = (dist_reg >= max_range_reg);

    for (genvar k = 0; k < DIV_CELLS; k++)
    begin : g_div
        p2s_div_cell u_cell (
            .clk     (clk),
            .divisor (max_range_reg),
            .din     (div_bus[k]),
            .dout    (div_bus[k+1])
        );
    end

    assign ratio = div_bus[DIV_CELLS].clamp ? 17'h10000 : {1'b0, div_bus[DIV_CELLS].quot};

    always_ff @(posedge clk)
    begin
        r_reg        <= R_W'(ratio * radius_reg);
        r_dly_reg[0] <= r_reg;
        for (int i = 1; i < R_DLY; i++)
        begin
            r_dly_reg[i] <= r_dly_reg[i-1];
        end
    end

    // Angle front end and the Taylor series cells.
    p2s_angle u_angle (
        .clk      (clk),
        .bearing  (bearing_reg),
        .ser_init (ser_bus[0]),
        .side     (side_a)
    );

    for (genvar k = 0; k < N_TERMS; k++)
    begin : g_ser
        ser_coef_t coef;
        assign coef.d_sin = SIN_DIV[k];
        assign coef.m_sin = SIN_RECIP[k];
        assign coef.d_cos = COS_DIV[k];
        assign coef.m_cos = COS_RECIP[k];
        assign coef.neg   = (k % 2 == 0);
        p2s_ser_cell u_cell (
            .clk  (clk),
            .coef (coef),
            .din  (ser_bus[k]),
            .dout (ser_bus[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        side_dly_reg[0] <= side_a;
        for (int i = 1; i < SER_LAT; i++)
        begin
            side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // Clip, round to trig precision, undo the fold.
    always_comb
    begin
        priority if (ser_bus[N_TERMS].ss < 0)
            s_clip = '0;
        else if (ser_bus[N_TERMS].ss > $signed({2'b00, ONE_Q31}))
            s_clip = ONE_Q31;
        else
            s_clip = ser_bus[N_TERMS].ss[31:0];
        priority if (ser_bus[N_TERMS].cs < 0)
            c_clip = '0;
        else if (ser_bus[N_TERMS].cs > $signed({2'b00, ONE_Q31}))
            c_clip = ONE_Q31;
        else
            c_clip = ser_bus[N_TERMS].cs[31:0];
        s_rnd = 33'({1'b0, s_clip} + (33'd1 << (TRIG_SH - 1)));
        c_rnd = 33'({1'b0, c_clip} + (33'd1 << (TRIG_SH - 1)));
        if (side_dly_reg[SER_LAT-1].swap)
        begin
            s_t = c_rnd[TRIG_SH +: TRIG_W];
            c_t = s_rnd[TRIG_SH +: TRIG_W];
        end
        else
        begin
            s_t = s_rnd[TRIG_SH +: TRIG_W];
            c_t = c_rnd[TRIG_SH +: TRIG_W];
        end
        unique case (side_dly_reg[SER_LAT-1].quad)
            2'd0:
            begin
                xmag_next = s_t; xneg_next = 1'b0;
                ymag_next = c_t; ysub_next = 1'b1;
            end
            2'd1:
            begin
                xmag_next = c_t; xneg_next = 1'b0;
                ymag_next = s_t; ysub_next = 1'b0;
            end
            2'd2:
            begin
                xmag_next = s_t; xneg_next = 1'b1;
                ymag_next = c_t; ysub_next = 1'b0;
            end
            default:
            begin
                xmag_next = c_t; xneg_next = 1'b1;
                ymag_next = s_t; ysub_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        xmag_reg    <= xmag_next;
        ymag_reg    <= ymag_next;
        xneg_reg    <= xneg_next;
        ysub_reg    <= ysub_next;
        px_prod_reg <= PROD_W'(r_dly_reg[R_DLY-1] * xmag_reg);
        py_prod_reg <= PROD_W'(r_dly_reg[R_DLY-1] * ymag_reg);
        xneg2_reg   <= xneg_reg;
        ysub2_reg   <= ysub_reg;
    end

    // Round the offsets half away from zero and add to the center.
    always_comb
    begin
        px_rnd = (PROD_W+1)'({1'b0, px_prod_reg} + ((PROD_W+1)'(1) << (SH2 - 1)));
        py_rnd = (PROD_W+1)'({1'b0, py_prod_reg} + ((PROD_W+1)'(1) << (SH2 - 1)));
        offx   = 17'(px_rnd[PROD_W:SH2]);
        offy   = 17'(py_rnd[PROD_W:SH2]);
        cx17   = {center_x_reg[15], center_x_reg};
        cy17   = {center_y_reg[15], center_y_reg};
        if (max_range_reg == 16'd0 || radius_reg == 12'd0)
        begin
            pixel_x_next = cx17;
            pixel_y_next = cy17;
        end
        else
        begin
            pixel_x_next = xneg2_reg ? 17'(cx17 - offx) : 17'(cx17 + offx);
            pixel_y_next = ysub2_reg ? 17'(cy17 - offy) : 17'(cy17 + offy);
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
    end

    assign done    = v_reg[OUT_STAGE];
    assign pixel_x = $signed(pixel_x_reg);
    assign pixel_y = $signed(pixel_y_reg);

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, OUT_STAGE + 1))
        else $error("result beat without a matching start");

    a_zero_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (max_range_reg == 16'd0 || radius_reg == 12'd0)) |->
        (pixel_x_reg == {center_x_reg[15], center_x_reg} &&
         pixel_y_reg == {center_y_reg[15], center_y_reg}))
        else $error("zero range or radius must plot at the center");

    a_ring_x: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (17'(pixel_x_reg - {center_x_reg[15], center_x_reg} + {5'd0, radius_reg})
                  <= {4'd0, radius_reg, 1'b0}))
        else $error("x offset beyond the outer ring");

    a_ring_y: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (17'(pixel_y_reg - {center_y_reg[15], center_y_reg} + {5'd0, radius_reg})
                  <= {4'd0, radius_reg, 1'b0}))
        else $error("y offset beyond the outer ring");
`endif

endmodule

`default_nettype wire

>>> hdl/p2s_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module p2s_div_cell (
    input  wire logic          clk,
    input  wire logic [15:0]   divisor,
    input  wire p2s_pkg::div_t din,
    output p2s_pkg::div_t      dout
);
    import p2s_pkg::*;

    logic [16:0] rem_s;
    logic        ge;
    div_t        dout_reg;
    div_t        dout_next;

    // One restoring step: shift, compare, subtract, one quotient bit.
    always_comb
    begin
        rem_s = {din.rem, 1'b0};
        ge    = (rem_s >= {1'b0, divisor});
        dout_next.rem   = ge ? 16'(rem_s - {1'b0, divisor}) : rem_s[15:0];
        dout_next.quot  = {din.quot[14:0], ge};
        dout_next.clamp = din.clamp;
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

>>> hdl/p2s_ser_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module p2s_ser_cell (
    input  wire logic               clk,
    input  wire p2s_pkg::ser_coef_t coef,
    input  wire p2s_pkg::ser_t      din,
    output p2s_pkg::ser_t           dout
);
    import p2s_pkg::*;

    logic [62:0]        ps1_reg;
    logic [62:0]        pc1_reg;
    logic [30:0]        x2_1_reg;
    logic signed [33:0] ss1_reg;
    logic signed [33:0] cs1_reg;

    logic [31:0]        vs2_reg;
    logic [31:0]        vc2_reg;
    logic [63:0]        ms2_reg;
    logic [63:0]        mc2_reg;
    logic [30:0]        x2_2_reg;
    logic signed [33:0] ss2_reg;
    logic signed [33:0] cs2_reg;

    logic [31:0] qs;
    logic [31:0] qc;
    logic [31:0] rs;
    logic [31:0] rc;
    logic [31:0] ts_new;
    logic [31:0] tc_new;
    ser_t        dout_reg;
    ser_t        dout_next;

    // Next term numerators: previous term times x squared.
    always_ff @(posedge clk)
    begin
        ps1_reg  <= 63'(din.ts * din.x2);
        pc1_reg  <= 63'(din.tc * din.x2);
        x2_1_reg <= din.x2;
        ss1_reg  <= din.ss;
        cs1_reg  <= din.cs;
    end

    // Divide by the term constant through its reciprocal.
    always_ff @(posedge clk)
    begin
        vs2_reg  <= ps1_reg[62:31];
        vc2_reg  <= pc1_reg[62:31];
        ms2_reg  <= 64'(ps1_reg[62:31] * coef.m_sin);
        mc2_reg  <= 64'(pc1_reg[62:31] * coef.m_cos);
        x2_2_reg <= x2_1_reg;
        ss2_reg  <= ss1_reg;
        cs2_reg  <= cs1_reg;
    end

    // The reciprocal estimate is low by at most one; fix it and accumulate.
    always_comb
    begin
        qs     = ms2_reg[63:32];
        qc     = mc2_reg[63:32];
        rs     = 32'(vs2_reg - 32'(qs * coef.d_sin));
        rc     = 32'(vc2_reg - 32'(qc * coef.d_cos));
        ts_new = 32'(qs + ((rs >= {24'd0, coef.d_sin}) ? 32'd1 : 32'd0));
        tc_new = 32'(qc + ((rc >= {24'd0, coef.d_cos}) ? 32'd1 : 32'd0));
        dout_next.ts = ts_new;
        dout_next.tc = tc_new;
        dout_next.x2 = x2_2_reg;
        if (coef.neg)
        begin
            dout_next.ss = 34'(ss2_reg - $signed({2'b00, ts_new}));
            dout_next.cs = 34'(cs2_reg - $signed({2'b00, tc_new}));
        end
        else
        begin
            dout_next.ss = 34'(ss2_reg + $signed({2'b00, ts_new}));
            dout_next.cs = 34'(cs2_reg + $signed({2'b00, tc_new}));
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

>>> hdl/p2s_angle.sv
`timescale 1ns / 1ps
`default_nettype none

module p2s_angle (
    input  wire logic               clk,
    input  wire logic signed [15:0] bearing,
    output p2s_pkg::ser_t           ser_init,
    output p2s_pkg::side_t          side
);
    import p2s_pkg::*;

    localparam logic [49:0] PI_Q48   = 50'h3243F6A8885A3;
    localparam logic [24:0] PI_LO    = PI_Q48[24:0];
    localparam logic [24:0] PI_HI    = PI_Q48[49:25];
    localparam logic [37:0] DEN_HALF = 38'd754974720;
    localparam logic [31:0] M45      = 32'(64'd137438953472 / 45);

    logic [17:0] u;
    logic [16:0] w;
    logic [14:0] bu;
    logic [12:0] a;
    logic [11:0] fa;
    side_t       side_next;

    logic [11:0] fa_reg;
    logic [36:0] phi_reg;
    logic [36:0] plo_reg;
    logic [36:0] x3_reg;
    logic [50:0] m1_reg;
    logic [49:0] m2_reg;
    logic [36:0] x4_reg;
    logic [30:0] q5_reg;
    logic [36:0] x5_reg;
    logic [36:0] rem6;
    logic [30:0] ang_reg;
    logic [61:0] sq_reg;
    logic [30:0] ang7_reg;
    ser_t        init_reg;
    side_t       side_reg [ANGLE_LAT];

    // Bearing modulo a full turn, then quadrant and octant fold.
    always_comb
    begin
        u = 18'($signed({{2{bearing[15]}}, bearing}) + 18'sd46080);
        priority if (u >= 18'd69120)
            w = 17'(u - 18'd69120);
        else if (u >= 18'd46080)
            w = 17'(u - 18'd46080);
        else if (u >= 18'd23040)
            w = 17'(u - 18'd23040);
        else
            w = u[16:0];
        bu = w[14:0];
        priority if (bu >= 15'd17280)
        begin
            side_next.quad = 2'd3;
            a = 13'(bu - 15'd17280);
        end
        else if (bu >= 15'd11520)
        begin
            side_next.quad = 2'd2;
            a = 13'(bu - 15'd11520);
        end
        else if (bu >= 15'd5760)
        begin
            side_next.quad = 2'd1;
            a = 13'(bu - 15'd5760);
        end
        else
        begin
            side_next.quad = 2'd0;
            a = bu[12:0];
        end
        if (a <= 13'd2880)
        begin
            fa = a[11:0];
            side_next.swap = 1'b0;
        end
        else
        begin
            fa = 12'(13'd5760 - a);
            side_next.swap = 1'b1;
        end
    end

    // Angle times pi in two partial products.
    always_ff @(posedge clk)
    begin
        fa_reg  <= fa;
        phi_reg <= 37'(fa_reg * PI_HI);
        plo_reg <= 37'(fa_reg * PI_LO);
        x3_reg  <= 37'(phi_reg + 37'((38'(plo_reg) + DEN_HALF) >> 25));
    end

    // Divide by 45 through a reciprocal, again in two partial products.
    always_ff @(posedge clk)
    begin
        m1_reg <= 51'(x3_reg[36:18] * M45);
        m2_reg <= 50'(x3_reg[17:0] * M45);
        x4_reg <= x3_reg;
        q5_reg <= 31'((52'(m1_reg) + 52'(m2_reg >> 18)) >> 19);
        x5_reg <= x4_reg;
    end

    // The estimate is low by at most one.
    assign rem6 = 37'(x5_reg - 37'(q5_reg * 6'd45));

    always_ff @(posedge clk)
    begin
        ang_reg  <= 31'(q5_reg + ((rem6 >= 37'd45) ? 31'd1 : 31'd0));
        sq_reg   <= 62'(ang_reg * ang_reg);
        ang7_reg <= ang_reg;
        init_reg.ts <= {1'b0, ang7_reg};
        init_reg.tc <= ONE_Q31;
        init_reg.x2 <= sq_reg[61:31];
        init_reg.ss <= $signed({3'b000, ang7_reg});
        init_reg.cs <= $signed({2'b00, ONE_Q31});
    end

    // Fold flags travel alongside the angle.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < ANGLE_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign ser_init = init_reg;
    assign side     = side_reg[ANGLE_LAT-1];

endmodule

`default_nettype wire
